FILE: design/angle_kalman_filter_macros.svh
`ifndef ANGLE_KALMAN_FILTER_MACROS_SVH
`define ANGLE_KALMAN_FILTER_MACROS_SVH

// same-cycle implication, checked on clk_i and disabled during reset
`define AKF_ASSERT(name, prop, msg) \
  name: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) else $error(msg);

// next-cycle implication, checked on clk_i and disabled during reset
`define AKF_ASSERT_NEXT(name, ante, cons, msg) \
  name: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

FILE: design/akf_pkg.sv
package akf_pkg;

  localparam logic [31:0]        OneQ16   = 32'd65536;
  localparam logic [31:0]        FullTurn = 32'd23592960;
  localparam logic signed [33:0] HalfTurn = 34'sd11796480;
  localparam logic signed [24:0] HalfTurnS = 25'sd11796480;

  localparam int WrapSteps = 7;
  localparam int WrapCntW  = $clog2(WrapSteps);
  localparam int DivSteps  = 17;
  localparam int DivCntW   = $clog2(DivSteps);

  typedef enum logic [1:0] {
    OP_PREDICT = 2'd0,
    OP_UPDATE  = 2'd1,
    OP_REINIT  = 2'd2
  } akf_op_e;

  typedef enum logic [0:0] {
    REG_PROCESS_NOISE     = 1'b0,
    REG_MEASUREMENT_NOISE = 1'b1
  } akf_reg_e;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_PR_MUL_RATE,
    ST_PR_MUL_Q,
    ST_PR_COV,
    ST_UP_START,
    ST_UP_WAIT,
    ST_UP_MUL_ERR,
    ST_UP_MUL_GAIN,
    ST_UP_COV,
    ST_UP_WRAP_WAIT,
    ST_UP_OUT
  } akf_state_e;

  typedef enum logic [1:0] {
    MUL_RATE_DT,
    MUL_Q_DT,
    MUL_K_ERR,
    MUL_GAIN_P
  } akf_mul_sel_e;

  typedef enum logic [1:0] {
    WRAP_PASS,
    WRAP_POS,
    WRAP_NEG
  } akf_wrap_mode_e;

  typedef struct packed {
    logic         capture;
    logic         reinit;
    akf_mul_sel_e mul_sel;
    logic         mul_en;
    logic         pred_angle;
    logic         pred_cov;
    logic         start_est;
    logic         hold_err;
    logic         start_angle;
    logic         upd_cov;
    logic         upd_angle;
    logic         load_out;
  } akf_cmd_t;

  typedef struct packed {
    logic div_done;
    logic wrap_done;
  } akf_status_t;

endpackage

FILE: design/angle_kalman_filter.sv
// Scalar Kalman filter for an angle in degrees, state and noise terms in Q16.16.
// One request is worked at a time; in_stall_o is high from acceptance until the
// request is finished. Predict runs rate, noise and covariance states in turn;
// reinitialise and unused codes end on acceptance. Update is paced mostly by the
// 17-step restoring gain divider; the error wrap (7 steps) runs beside it, then
// two passes through the shared 18x33 multiplier and a second 7-step wrap of the
// corrected angle. The result sits in an output register, so it may wait for the
// sink while the next request is accepted; an update finding it full holds until
// taken. Write noise registers via cfg_we_i at idle time; not enforced by the block.
module angle_kalman_filter (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               cfg_we_i,
  input  logic [0:0]         cfg_index_i,
  input  logic [23:0]        cfg_wdata_i,
  input  logic               in_valid_i,
  output logic               in_stall_o,
  input  logic [1:0]         operation_i,
  input  logic signed [27:0] gyro_rate_i,
  input  logic [16:0]        time_step_i,
  input  logic signed [24:0] measured_angle_i,
  output logic               out_valid_o,
  input  logic               out_stall_i,
  output logic signed [24:0] angle_out_o,
  output logic [31:0]        covariance_out_o
);

  akf_pkg::akf_cmd_t    cmd;
  akf_pkg::akf_status_t status;

  akf_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .operation_i (operation_i),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .status_i    (status),
    .cmd_o       (cmd)
  );

  akf_datapath u_datapath (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .cfg_we_i         (cfg_we_i),
    .cfg_index_i      (cfg_index_i),
    .cfg_wdata_i      (cfg_wdata_i),
    .gyro_rate_i      (gyro_rate_i),
    .time_step_i      (time_step_i),
    .measured_angle_i (measured_angle_i),
    .cmd_i            (cmd),
    .status_o         (status),
    .angle_out_o      (angle_out_o),
    .covariance_out_o (covariance_out_o)
  );

endmodule

FILE: design/akf_div.sv
module akf_div (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        start_i,
  input  logic [31:0] cov_i,
  input  logic [23:0] noise_i,
  output logic        done_o,
  output logic [16:0] gain_o
);

  logic                         busy_q, busy_d;
  logic                         done_q, done_d;
  logic [akf_pkg::DivCntW-1:0]  cnt_q, cnt_d;
  logic [32:0]                  den_q, den_d;
  logic [32:0]                  rem_q, rem_d;
  logic [16:0]                  num_q, num_d;
  logic [16:0]                  quo_q, quo_d;
  logic [33:0]                  trial;
  logic [32:0]                  den_start;
  logic                         ge;

  assign den_start = {1'b0, cov_i} + {9'b0, noise_i};
  assign trial     = {rem_q, num_q[16]};
  assign ge        = trial >= {1'b0, den_q};

  always_comb begin
    busy_d = busy_q;
    done_d = done_q;
    cnt_d  = cnt_q;
    den_d  = den_q;
    rem_d  = rem_q;
    num_d  = num_q;
    quo_d  = quo_q;
    if (start_i) begin
      den_d = den_start;
      rem_d = {2'b0, cov_i[31:1]};
      num_d = {cov_i[0], 16'b0};
      quo_d = '0;
      cnt_d = akf_pkg::DivCntW'(akf_pkg::DivSteps - 1);
      if (den_start == '0) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end else begin
        busy_d = 1'b1;
        done_d = 1'b0;
      end
    end else if (busy_q) begin
      rem_d = ge ? 33'(trial - {1'b0, den_q}) : trial[32:0];
      num_d = {num_q[15:0], 1'b0};
      quo_d = {quo_q[15:0], ge};
      cnt_d = cnt_q - 1'b1;
      if (cnt_q == '0) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    den_q <= den_d;
    rem_q <= rem_d;
    num_q <= num_d;
    quo_q <= quo_d;
  end

  assign done_o = done_q;
  assign gain_o = quo_q;

endmodule

FILE: design/akf_wrap.sv
`include "angle_kalman_filter_macros.svh"

module akf_wrap (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               start_i,
  input  logic signed [33:0] value_i,
  output logic               done_o,
  output logic signed [24:0] result_o
);

  logic                           busy_q, busy_d;
  logic                           done_q, done_d;
  logic [akf_pkg::WrapCntW-1:0]   cnt_q, cnt_d;
  akf_pkg::akf_wrap_mode_e        mode_q, mode_d;
  logic [31:0]                    rem_q, rem_d;
  logic signed [24:0]             pass_q, pass_d;
  logic [32:0]                    step;
  logic signed [33:0]             pos_x, neg_x, pos_res, neg_res;

  assign step  = {1'b0, akf_pkg::FullTurn} << cnt_q;
  assign pos_x = value_i - akf_pkg::HalfTurn - 34'sd1;
  assign neg_x = -akf_pkg::HalfTurn - value_i - 34'sd1;

  always_comb begin
    busy_d = busy_q;
    done_d = done_q;
    cnt_d  = cnt_q;
    mode_d = mode_q;
    rem_d  = rem_q;
    pass_d = pass_q;
    if (start_i) begin
      cnt_d  = akf_pkg::WrapCntW'(akf_pkg::WrapSteps - 1);
      pass_d = value_i[24:0];
      if (value_i > akf_pkg::HalfTurn) begin
        mode_d = akf_pkg::WRAP_POS;
        rem_d  = pos_x[31:0];
        busy_d = 1'b1;
        done_d = 1'b0;
      end else if (value_i < -akf_pkg::HalfTurn) begin
        mode_d = akf_pkg::WRAP_NEG;
        rem_d  = neg_x[31:0];
        busy_d = 1'b1;
        done_d = 1'b0;
      end else begin
        mode_d = akf_pkg::WRAP_PASS;
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end else if (busy_q) begin
      if ({1'b0, rem_q} >= step) begin
        rem_d = 32'({1'b0, rem_q} - step);
      end
      cnt_d = cnt_q - 1'b1;
      if (cnt_q == '0) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
      mode_q <= akf_pkg::WRAP_PASS;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
      mode_q <= mode_d;
    end
  end

  always_ff @(posedge clk_i) begin
    rem_q  <= rem_d;
    pass_q <= pass_d;
  end

  assign pos_res = $signed({2'b0, rem_q}) + 34'sd1 - akf_pkg::HalfTurn;
  assign neg_res = akf_pkg::HalfTurn - $signed({2'b0, rem_q}) - 34'sd1;

  always_comb begin
    case (mode_q)
      akf_pkg::WRAP_POS:  result_o = pos_res[24:0];
      akf_pkg::WRAP_NEG:  result_o = neg_res[24:0];
      akf_pkg::WRAP_PASS: result_o = pass_q;
      default:            result_o = pass_q;
    endcase
  end

  assign done_o = done_q;

  `AKF_ASSERT(a_wrap_in_range, done_q |-> (result_o <= akf_pkg::HalfTurnS && result_o >= -akf_pkg::HalfTurnS), "wrapped angle out of range")

endmodule

FILE: design/akf_datapath.sv
`include "angle_kalman_filter_macros.svh"

module akf_datapath (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 cfg_we_i,
  input  logic [0:0]           cfg_index_i,
  input  logic [23:0]          cfg_wdata_i,
  input  logic signed [27:0]   gyro_rate_i,
  input  logic [16:0]          time_step_i,
  input  logic signed [24:0]   measured_angle_i,
  input  akf_pkg::akf_cmd_t    cmd_i,
  output akf_pkg::akf_status_t status_o,
  output logic signed [24:0]   angle_out_o,
  output logic [31:0]          covariance_out_o
);

  logic [23:0]        q_noise_q, r_noise_q;
  logic signed [27:0] rate_q;
  logic [16:0]        dt_q;
  logic signed [24:0] meas_q;
  logic signed [31:0] angle_q;
  logic [31:0]        cov_q;
  logic signed [50:0] prod_q, prod_d;
  logic signed [24:0] err_q;
  logic signed [24:0] angle_out_q;
  logic [31:0]        cov_out_q;

  logic signed [17:0] mul_a;
  logic signed [32:0] mul_b;
  logic signed [50:0] rnd_sum;
  logic signed [34:0] rnd;
  logic signed [33:0] angle_ext, pred_sum, err_in, upd_in, wrap_in;
  logic [32:0]        cov_sum;
  logic signed [31:0] pred_angle;
  logic [31:0]        pred_cov;
  logic [16:0]        gain;
  logic               div_done, wrap_done;
  logic signed [24:0] wrap_res;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      q_noise_q <= 24'd66;
      r_noise_q <= 24'd3277;
    end else if (cfg_we_i) begin
      case (akf_pkg::akf_reg_e'(cfg_index_i))
        akf_pkg::REG_PROCESS_NOISE:     q_noise_q <= cfg_wdata_i;
        akf_pkg::REG_MEASUREMENT_NOISE: r_noise_q <= cfg_wdata_i;
        default: ;
      endcase
    end
  end

  always_comb begin
    case (cmd_i.mul_sel)
      akf_pkg::MUL_RATE_DT: begin
        mul_a = $signed({1'b0, dt_q});
        mul_b = {{5{rate_q[27]}}, rate_q};
      end
      akf_pkg::MUL_Q_DT: begin
        mul_a = $signed({1'b0, dt_q});
        mul_b = $signed({9'b0, q_noise_q});
      end
      akf_pkg::MUL_K_ERR: begin
        mul_a = $signed({1'b0, gain});
        mul_b = {{8{err_q[24]}}, err_q};
      end
      akf_pkg::MUL_GAIN_P: begin
        mul_a = $signed({1'b0, 17'(akf_pkg::OneQ16) - gain});
        mul_b = $signed({1'b0, cov_q});
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
  end

  assign prod_d  = mul_a * mul_b;
  assign rnd_sum = prod_q + 51'sd32768;
  assign rnd     = rnd_sum[50:16];

  assign angle_ext = {{2{angle_q[31]}}, angle_q};
  assign pred_sum  = angle_ext + rnd[33:0];
  assign cov_sum   = {1'b0, cov_q} + rnd[32:0];
  assign err_in    = {{9{meas_q[24]}}, meas_q} - angle_ext;
  assign upd_in    = angle_ext + rnd[33:0];
  assign wrap_in   = cmd_i.start_est ? err_in : upd_in;

  always_comb begin
    if (!pred_sum[33] && (pred_sum[32:31] != 2'b00)) begin
      pred_angle = {1'b0, {31{1'b1}}};
    end else if (pred_sum[33] && (pred_sum[32:31] != 2'b11)) begin
      pred_angle = {1'b1, 31'b0};
    end else begin
      pred_angle = pred_sum[31:0];
    end
  end

  assign pred_cov = cov_sum[32] ? '1 : cov_sum[31:0];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      angle_q <= '0;
      cov_q   <= akf_pkg::OneQ16;
    end else if (cmd_i.reinit) begin
      angle_q <= '0;
      cov_q   <= akf_pkg::OneQ16;
    end else begin
      if (cmd_i.pred_angle) begin
        angle_q <= pred_angle;
      end else if (cmd_i.upd_angle) begin
        angle_q <= 32'(wrap_res);
      end
      if (cmd_i.pred_cov) begin
        cov_q <= pred_cov;
      end else if (cmd_i.upd_cov) begin
        cov_q <= rnd[31:0];
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.capture) begin
      rate_q <= gyro_rate_i;
      dt_q   <= time_step_i;
      meas_q <= measured_angle_i;
    end
    if (cmd_i.mul_en) begin
      prod_q <= prod_d;
    end
    if (cmd_i.hold_err) begin
      err_q <= wrap_res;
    end
    if (cmd_i.load_out) begin
      angle_out_q <= angle_q[24:0];
      cov_out_q   <= cov_q;
    end
  end

  akf_div u_div (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (cmd_i.start_est),
    .cov_i   (cov_q),
    .noise_i (r_noise_q),
    .done_o  (div_done),
    .gain_o  (gain)
  );

  akf_wrap u_wrap (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .start_i  (cmd_i.start_est | cmd_i.start_angle),
    .value_i  (wrap_in),
    .done_o   (wrap_done),
    .result_o (wrap_res)
  );

  assign status_o.div_done  = div_done;
  assign status_o.wrap_done = wrap_done;
  assign angle_out_o        = angle_out_q;
  assign covariance_out_o   = cov_out_q;

  `AKF_ASSERT_NEXT(a_cov_no_growth, cmd_i.upd_cov && !cmd_i.reinit, cov_q <= $past(cov_q), "covariance grew on update")
  `AKF_ASSERT(a_gain_bound, div_done |-> gain <= 17'(akf_pkg::OneQ16), "gain above one")

endmodule

FILE: design/akf_ctrl.sv
`include "angle_kalman_filter_macros.svh"

module akf_ctrl (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 in_valid_i,
  output logic                 in_stall_o,
  input  logic [1:0]           operation_i,
  output logic                 out_valid_o,
  input  logic                 out_stall_i,
  input  akf_pkg::akf_status_t status_i,
  output akf_pkg::akf_cmd_t    cmd_o
);

  akf_pkg::akf_state_e state_q, state_d;
  logic                out_valid_q, out_valid_d;
  logic                accept;
  logic                out_free;

  assign accept   = in_valid_i && (state_q == akf_pkg::ST_IDLE);
  assign out_free = !out_valid_q || !out_stall_i;

  always_comb begin
    state_d = state_q;
    case (state_q)
      akf_pkg::ST_IDLE: begin
        if (accept) begin
          case (akf_pkg::akf_op_e'(operation_i))
            akf_pkg::OP_PREDICT: state_d = akf_pkg::ST_PR_MUL_RATE;
            akf_pkg::OP_UPDATE:  state_d = akf_pkg::ST_UP_START;
            default:             state_d = akf_pkg::ST_IDLE;
          endcase
        end
      end
      akf_pkg::ST_PR_MUL_RATE: state_d = akf_pkg::ST_PR_MUL_Q;
      akf_pkg::ST_PR_MUL_Q:    state_d = akf_pkg::ST_PR_COV;
      akf_pkg::ST_PR_COV:      state_d = akf_pkg::ST_IDLE;
      akf_pkg::ST_UP_START:    state_d = akf_pkg::ST_UP_WAIT;
      akf_pkg::ST_UP_WAIT: begin
        if (status_i.div_done && status_i.wrap_done) begin
          state_d = akf_pkg::ST_UP_MUL_ERR;
        end
      end
      akf_pkg::ST_UP_MUL_ERR:  state_d = akf_pkg::ST_UP_MUL_GAIN;
      akf_pkg::ST_UP_MUL_GAIN: state_d = akf_pkg::ST_UP_COV;
      akf_pkg::ST_UP_COV:      state_d = akf_pkg::ST_UP_WRAP_WAIT;
      akf_pkg::ST_UP_WRAP_WAIT: begin
        if (status_i.wrap_done) begin
          state_d = akf_pkg::ST_UP_OUT;
        end
      end
      akf_pkg::ST_UP_OUT: begin
        if (out_free) begin
          state_d = akf_pkg::ST_IDLE;
        end
      end
      default: state_d = akf_pkg::ST_IDLE;
    endcase
  end

  always_comb begin
    cmd_o         = '0;
    cmd_o.mul_sel = akf_pkg::MUL_RATE_DT;
    case (state_q)
      akf_pkg::ST_IDLE: begin
        cmd_o.capture = accept;
        cmd_o.reinit  = accept && (operation_i == akf_pkg::OP_REINIT);
      end
      akf_pkg::ST_PR_MUL_RATE: begin
        cmd_o.mul_en  = 1'b1;
        cmd_o.mul_sel = akf_pkg::MUL_RATE_DT;
      end
      akf_pkg::ST_PR_MUL_Q: begin
        cmd_o.mul_en     = 1'b1;
        cmd_o.mul_sel    = akf_pkg::MUL_Q_DT;
        cmd_o.pred_angle = 1'b1;
      end
      akf_pkg::ST_PR_COV:   cmd_o.pred_cov  = 1'b1;
      akf_pkg::ST_UP_START: cmd_o.start_est = 1'b1;
      akf_pkg::ST_UP_WAIT:  cmd_o.hold_err  = status_i.div_done && status_i.wrap_done;
      akf_pkg::ST_UP_MUL_ERR: begin
        cmd_o.mul_en  = 1'b1;
        cmd_o.mul_sel = akf_pkg::MUL_K_ERR;
      end
      akf_pkg::ST_UP_MUL_GAIN: begin
        cmd_o.mul_en      = 1'b1;
        cmd_o.mul_sel     = akf_pkg::MUL_GAIN_P;
        cmd_o.start_angle = 1'b1;
      end
      akf_pkg::ST_UP_COV:       cmd_o.upd_cov   = 1'b1;
      akf_pkg::ST_UP_WRAP_WAIT: cmd_o.upd_angle = status_i.wrap_done;
      akf_pkg::ST_UP_OUT:       cmd_o.load_out  = out_free;
      default: ;
    endcase
  end

  always_comb begin
    if (cmd_o.load_out) begin
      out_valid_d = 1'b1;
    end else if (!out_stall_i) begin
      out_valid_d = 1'b0;
    end else begin
      out_valid_d = out_valid_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= akf_pkg::ST_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

  assign in_stall_o  = state_q != akf_pkg::ST_IDLE;
  assign out_valid_o = out_valid_q;

  `AKF_ASSERT(a_result_from_update, $rose(out_valid_q) |-> $past(state_q) == akf_pkg::ST_UP_OUT, "result raised outside update")

endmodule
